>>> hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int PFA_NUM_PARTITIONS_DEF = 16;
	localparam int SIZE_W                 = 20;
	localparam int PIDX_W                 = 4;
	localparam int CFG_DATA_W             = 5;
	localparam int CFG_IDX_W              = 1;

	localparam logic                  ACT_LOAD  = 1'b0;
	localparam logic                  ACT_ALLOC = 1'b1;

	localparam logic [1:0]            STRAT_FIRST = 2'd0;
	localparam logic [1:0]            STRAT_BEST  = 2'd1;
	localparam logic [1:0]            STRAT_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0]  REG_STRATEGY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_PARTS_IN_USE = 1'd1;

	localparam logic [4:0]            PARTS_IN_USE_RST = 5'd16;

	typedef struct packed {
		logic              action;
		logic [PIDX_W-1:0] partition_index;
		logic [SIZE_W-1:0] amount;
	} in_item_t;

	typedef struct packed {
		logic              granted;
		logic [PIDX_W-1:0] chosen_partition;
	} out_item_t;

	typedef struct packed {
		logic load;      // write table entry from the input transfer
		logic scan_go;   // capture request, restart scan
		logic issue;     // read next table entry
		logic commit;    // update chosen entry, emit result
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_end;  // all searched entries have been read
	} dp_stat_t;

endpackage

>>> hdl/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: accepts transfers, steps the table scan, triggers the commit.
// ----------------------------------------------------------------------------
module pfa_ctrl import pfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     action,
	output logic     busy,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && action == ACT_ALLOC) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (stat.scan_end) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start && (action == ACT_LOAD);
		cmd.scan_go = (state_q == ST_IDLE) && start && (action == ACT_ALLOC);
		cmd.issue   = (state_q == ST_SCAN) && !stat.scan_end;
		cmd.commit  = (state_q == ST_COMMIT);
	end

endmodule

>>> hdl/pfa_datapath.sv
// ----------------------------------------------------------------------------
// pfa_datapath
// Partition size table, configuration registers, one-entry-per-cycle fit
// compare and result register.
// ----------------------------------------------------------------------------
module pfa_datapath import pfa_pkg::*; #(
	parameter int NUM_PARTITIONS = PFA_NUM_PARTITIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              item,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  done,
	output out_item_t             result
);

	localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

	logic [SIZE_W-1:0]         mem [NUM_PARTITIONS];
	logic [NUM_PARTITIONS-1:0] valid_q;

	logic [1:0]                strategy_q;
	logic [4:0]                parts_in_use_q;

	logic [SIZE_W-1:0]         amount_q;
	logic [CNT_W-1:0]          addr_q;
	logic [CNT_W-1:0]          limit;
	logic [IDX_W-1:0]          rd_addr;

	logic                      rd_live_s1;
	logic [SIZE_W-1:0]         rd_size_s1;
	logic [IDX_W-1:0]          rd_idx_s1;

	logic                      found_q;
	logic [IDX_W-1:0]          pick_q;
	logic [SIZE_W-1:0]         pick_size_q;

	logic                      done_q;
	out_item_t                 result_q;

	logic                      load_ok;
	logic [IDX_W-1:0]          load_addr;
	logic                      fits;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q     <= STRAT_FIRST;
			parts_in_use_q <= PARTS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRATEGY:     strategy_q     <= cfg_wdata[1:0];
				REG_PARTS_IN_USE: parts_in_use_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(parts_in_use_q) >= NUM_PARTITIONS) begin
			limit = CNT_W'(NUM_PARTITIONS);
		end else begin
			limit = CNT_W'(parts_in_use_q);
		end
	end

	assign stat.scan_end = (addr_q >= limit);
	assign rd_addr       = addr_q[IDX_W-1:0];
	assign load_ok       = (32'(item.partition_index) < NUM_PARTITIONS);
	assign load_addr     = IDX_W'(item.partition_index);

	// table storage
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			mem[load_addr] <= item.amount;
		end else if (cmd.commit && found_q) begin
			mem[pick_q] <= pick_size_q - amount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.load && load_ok) begin
			valid_q[load_addr] <= 1'b1;
		end else if (cmd.commit && found_q) begin
			valid_q[pick_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_size_s1 <= valid_q[rd_addr] ? mem[rd_addr] : '0;
			rd_idx_s1  <= rd_addr;
		end
		if (cmd.scan_go) begin
			amount_q <= item.amount;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			rd_live_s1 <= 1'b0;
		end else begin
			rd_live_s1 <= cmd.issue;
			if (cmd.scan_go) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// fit compare, ties keep the lower index
	assign fits = rd_live_s1 && (amount_q <= rd_size_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_go) begin
			found_q <= 1'b0;
		end else if (fits) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fits) begin
			if (!found_q) begin
				pick_q      <= rd_idx_s1;
				pick_size_q <= rd_size_s1;
			end else begin
				case (strategy_q)
					STRAT_BEST: begin
						if (rd_size_s1 < pick_size_q) begin
							pick_q      <= rd_idx_s1;
							pick_size_q <= rd_size_s1;
						end
					end
					STRAT_WORST: begin
						if (rd_size_s1 > pick_size_q) begin
							pick_q      <= rd_idx_s1;
							pick_size_q <= rd_size_s1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.granted          <= found_q;
			result_q.chosen_partition <= found_q ? PIDX_W'(pick_q) : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> hdl/partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator
// First, best and worst fit partition allocator over a table of sizes.
// ----------------------------------------------------------------------------
// Load transfer: accepted while idle, no result; busy stays low.
// Allocate transfer: the scan reads the first L table entries, where
// L = min(partitions_in_use, NUM_PARTITIONS), one entry per cycle through
// a single memory read port; a commit state then updates the chosen
// entry and registers result and done. A new transfer is accepted in the
// cycle that shows done, none while busy. The receiver cannot stall; done
// lasts one cycle. Reset clears the table to zero, strategy to first fit,
// and partitions_in_use to 16.
module partition_fit_allocator import pfa_pkg::*; #(
	parameter int NUM_PARTITIONS = PFA_NUM_PARTITIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  done,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	pfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	pfa_datapath #(
		.NUM_PARTITIONS (NUM_PARTITIONS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule
